// ----- hw/rtl/sbpb_pkg.sv -----
`default_nettype none
package sbpb_pkg;

    localparam int BANDS       = 256;
    localparam int BAND_W      = $clog2(BANDS);
    localparam int LEVEL_W     = 24;
    localparam int HEIGHT_W    = 20;
    localparam int SPEED_W     = 24;
    localparam int PIX_W       = 12;
    localparam int FRAC_W      = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int DEC_W       = 13;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 24'd655;
    localparam logic [14:0]        LOG10_2_Q16 = 15'd19728;

    // floor(y/125) = (y * M) >> SHIFT, exact over the stated dividend width
    localparam logic [31:0] DIV125_M31     = 32'd2199023256;  // y < 2^31, shift 38
    localparam logic [20:0] DIV125_M20     = 21'd1073742;     // y < 2^20, shift 27
    localparam logic [32:0] SPEED_SAT_Y    = 33'd2097152000;  // 125 * 2^24
    localparam logic [35:0] ROUND_THOUSAND = 36'd500;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOG_SCALE    = 8'd0,
        REG_HEIGHT_LIMIT = 8'd1,
        REG_BAR_DECAY    = 8'd2,
        REG_PEAK_ACCEL   = 8'd3
    } reg_index_t;

    typedef struct packed {
        logic [BAND_W-1:0]  band;
        logic [LEVEL_W-1:0] level;
        logic               update;
    } item_t;

    typedef struct packed {
        logic [BAND_W-1:0] band_out;
        logic [PIX_W-1:0]  bar_pixels;
        logic [PIX_W-1:0]  peak_pixels;
    } result_t;

    typedef struct packed {
        logic [15:0] log_scale;
        logic [11:0] height_limit;
        logic [13:0] bar_decay;
        logic [10:0] peak_accel;
    } cfg_t;

    typedef struct packed {
        logic [BAND_W-1:0]   band;
        logic [HEIGHT_W-1:0] height;
        logic                update;
    } job_t;

    typedef logic [15:0] mant_tab_t [64];

    // log2(1 + m/64) in Q0.16 by repeated squaring in Q2.30
    function automatic mant_tab_t mant_log_table();
        mant_tab_t   t;
        logic [63:0] y;
        logic [15:0] r;
        for (int m = 0; m < 64; m++)
        begin
            y = 64'(64 + m) << 24;
            r = '0;
            for (int b = 15; b >= 0; b--)
            begin
                y = (y * y) >> 30;
                if (y >= (64'd2 << 30))
                begin
                    r[b] = 1'b1;
                    y    = y >> 1;
                end
            end
            t[m] = r;
        end
        return t;
    endfunction

    localparam mant_tab_t MANT_LOG = mant_log_table();

endpackage
`default_nettype wire

// ----- hw/rtl/sbpb_front.sv -----
`default_nettype none
module sbpb_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire sbpb_pkg::item_t  item,
    input  wire sbpb_pkg::cfg_t   cfg,
    input  wire logic             q_full,
    output logic                  push,
    output sbpb_pkg::job_t        job
);
    import sbpb_pkg::*;

    logic                fadv;
    logic [4:0]          p_w;
    logic [4:0]          sa;
    logic [5:0]          mant;
    logic [19:0]         lpos;
    logic [34:0]         dprod;
    logic [34:0]         hprod;
    logic [HEIGHT_W-1:0] lim;
    logic [HEIGHT_W-1:0] h_ext;

    logic                f1_valid_reg, f2_valid_reg, f3_valid_reg;
    logic [BAND_W-1:0]   f1_band_reg, f2_band_reg, f3_band_reg;
    logic                f1_upd_reg, f2_upd_reg, f3_upd_reg;
    logic [19:0]         f1_l_reg;
    logic [18:0]         f2_d_reg;
    logic [18:0]         f3_h_reg;

    assign fadv       = !f3_valid_reg || !q_full;
    assign item_stall = !fadv;

    // leading one, then mantissa index from the six bits below it
    always_comb
    begin
        p_w = '0;
        for (int k = 0; k < LEVEL_W; k++)
        begin
            if (item.level[k])
                p_w = 5'(k);
        end
        sa   = p_w - 5'd6;
        mant = 6'(item.level >> sa);
        // below p = 8 the log is never positive, so the height is zero
        lpos = (p_w >= 5'd8) ? {4'(p_w - 5'd8), MANT_LOG[mant]} : '0;
    end

    assign dprod = {15'd0, f1_l_reg} * {20'd0, LOG10_2_Q16};
    assign hprod = {16'd0, f2_d_reg} * {19'd0, cfg.log_scale};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else if (fadv)
        begin
            f1_valid_reg <= item_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fadv)
        begin
            f1_band_reg <= item.band;
            f1_upd_reg  <= item.update;
            f1_l_reg    <= lpos;
            f2_band_reg <= f1_band_reg;
            f2_upd_reg  <= f1_upd_reg;
            f2_d_reg    <= dprod[34:16];
            f3_band_reg <= f2_band_reg;
            f3_upd_reg  <= f2_upd_reg;
            f3_h_reg    <= hprod[34:16];
        end
    end

    assign lim   = {cfg.height_limit, 8'd0};
    assign h_ext = {1'b0, f3_h_reg};

    assign push       = f3_valid_reg && fadv;
    assign job.band   = f3_band_reg;
    assign job.update = f3_upd_reg;
    assign job.height = (h_ext > lim) ? lim : h_ext;

endmodule
`default_nettype wire

// ----- hw/rtl/sbpb_queue.sv -----
`default_nettype none
module sbpb_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire sbpb_pkg::job_t  push_job,
    output logic                 full,
    input  wire logic            pop,
    output logic                 head_valid,
    output sbpb_pkg::job_t       head
);
    import sbpb_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("queue pop while empty");

endmodule
`default_nettype wire

// ----- hw/rtl/sbpb_back.sv -----
`default_nettype none
module sbpb_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire sbpb_pkg::cfg_t  cfg,
    input  wire logic            head_valid,
    input  wire sbpb_pkg::job_t  head,
    output logic                 pop,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output sbpb_pkg::result_t    result
);
    import sbpb_pkg::*;

    typedef struct packed {
        logic [HEIGHT_W-1:0] bar;
        logic [HEIGHT_W-1:0] peak;
        logic [SPEED_W-1:0]  spd;
    } entry_t;

    typedef enum logic [2:0] {
        SPD_HOLD  = 3'b001,
        SPD_RESET = 3'b010,
        SPD_GROW  = 3'b100
    } spd_mode_t;

    typedef struct packed {
        logic [BAND_W-1:0]   band;
        logic                update;
        logic [HEIGHT_W-1:0] bar;
        logic [HEIGHT_W-1:0] peak;
        logic [SPEED_W-1:0]  spd;
        spd_mode_t           mode;
    } stage_t;

    localparam entry_t ENTRY_RESET = '{bar: '0, peak: '0, spd: SPEED_RESET};

    entry_t              mem [BANDS];
    logic [BANDS-1:0]    written_reg;
    entry_t              rd_reg;
    logic                rd_written_reg;

    logic                adv, hazard, wr_en;
    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic [BAND_W-1:0]   s1_band_reg;
    logic [HEIGHT_W-1:0] s1_h_reg;
    logic                s1_upd_reg;
    stage_t              s2_reg, s3_reg, s2_next;
    logic [34:0]         s2_prod_reg;
    logic [62:0]         s3_prod_reg;
    logic                s3_sat_reg;
    result_t             out_reg;
    logic [DEC_W-1:0]    dec_reg;

    entry_t              cur;
    logic                rise, catch_pk;
    logic [HEIGHT_W-1:0] bar_n, pk_fall, pk_floor;
    logic [16:0]         step;
    logic [24:0]         step_sum;
    logic [34:0]         prod1;
    logic [35:0]         sum1;
    logic [32:0]         y;
    logic [62:0]         prod2;
    logic [SPEED_W-1:0]  spd_w;
    logic [22:0]         dec_num;
    logic [40:0]         dec_prod;

    assign adv = !out_valid_reg || !result_stall;

    // a band still in flight with an update has not landed in memory yet
    assign hazard = (s1_valid_reg && s1_upd_reg && (s1_band_reg == head.band))
                 || (s2_valid_reg && s2_reg.update && (s2_reg.band == head.band))
                 || (s3_valid_reg && s3_reg.update && (s3_reg.band == head.band));

    assign pop   = adv && head_valid && !hazard;
    assign wr_en = adv && s3_valid_reg && s3_reg.update;

    // bar decay step, round(bar_decay * 256 / 1000)
    assign dec_num  = {1'b0, cfg.bar_decay, 8'd0} + 23'd500;
    assign dec_prod = {21'd0, dec_num[22:3]} * {20'd0, DIV125_M20};

    always_comb
    begin
        cur      = rd_written_reg ? rd_reg : ENTRY_RESET;
        rise     = s1_h_reg > cur.bar;
        catch_pk = rise && (s1_h_reg > cur.peak);
        if (rise)
            bar_n = s1_h_reg;
        else if (cur.bar > HEIGHT_W'(dec_reg))
            bar_n = cur.bar - HEIGHT_W'(dec_reg);
        else
            bar_n = '0;
        step_sum = {1'b0, cur.spd} + 25'd128;
        step     = step_sum[24:8];
        pk_fall  = (cur.peak > HEIGHT_W'(step)) ? cur.peak - HEIGHT_W'(step) : '0;
        pk_floor = (pk_fall < bar_n) ? bar_n : pk_fall;

        s2_next.band   = s1_band_reg;
        s2_next.update = s1_upd_reg;
        s2_next.spd    = cur.spd;
        if (!s1_upd_reg)
        begin
            s2_next.bar  = cur.bar;
            s2_next.peak = cur.peak;
            s2_next.mode = SPD_HOLD;
        end
        else if (catch_pk)
        begin
            s2_next.bar  = bar_n;
            s2_next.peak = s1_h_reg;
            s2_next.mode = SPD_RESET;
        end
        else if (cur.peak != '0)
        begin
            s2_next.bar  = bar_n;
            s2_next.peak = pk_floor;
            s2_next.mode = SPD_GROW;
        end
        else
        begin
            s2_next.bar  = bar_n;
            s2_next.peak = cur.peak;
            s2_next.mode = SPD_HOLD;
        end
    end

    assign prod1 = {11'd0, cur.spd} * {24'd0, cfg.peak_accel};

    // (x + 500) / 1000 taken as ((x + 500) >> 3) / 125
    assign sum1  = {1'b0, s2_prod_reg} + ROUND_THOUSAND;
    assign y     = sum1[35:3];
    assign prod2 = {32'd0, y[30:0]} * {31'd0, DIV125_M31};

    always_comb
    begin
        case (s3_reg.mode)
            SPD_GROW:  spd_w = s3_sat_reg ? {SPEED_W{1'b1}} : s3_prod_reg[61:38];
            SPD_RESET: spd_w = SPEED_RESET;
            SPD_HOLD:  spd_w = s3_reg.spd;
            default:   spd_w = s3_reg.spd;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            written_reg   <= '0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg  <= pop;
                s2_valid_reg  <= s1_valid_reg;
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
            if (wr_en)
                written_reg[s3_reg.band] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_prod[39:27];
        if (wr_en)
            mem[s3_reg.band] <= '{bar: s3_reg.bar, peak: s3_reg.peak, spd: spd_w};
        if (adv)
        begin
            rd_reg         <= mem[head.band];
            rd_written_reg <= written_reg[head.band];
            s1_band_reg    <= head.band;
            s1_h_reg       <= head.height;
            s1_upd_reg     <= head.update;
            s2_reg         <= s2_next;
            s2_prod_reg    <= prod1;
            s3_reg         <= s2_reg;
            s3_prod_reg    <= prod2;
            s3_sat_reg     <= (y >= SPEED_SAT_Y);
            out_reg.band_out    <= s3_reg.band;
            out_reg.bar_pixels  <= s3_reg.bar[HEIGHT_W-1:FRAC_W];
            out_reg.peak_pixels <= s3_reg.peak[HEIGHT_W-1:FRAC_W];
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_no_raw: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && s3_valid_reg && s3_reg.update) |-> (head.band != s3_reg.band))
        else $error("band read while its write is pending");
    a_peak_above_bar: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_reg.peak >= s3_reg.bar))
        else $error("peak below bar");
    a_catch_level: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && (s3_reg.mode == SPD_RESET)) |-> (s3_reg.peak == s3_reg.bar))
        else $error("new peak differs from bar");

endmodule
`default_nettype wire

// ----- hw/rtl/spectrum_bar_peak_ballistics_top.sv -----
`default_nettype none
// Bar graph meter with peak hold, one spectrum band per beat. Each item gives
// a band index and magnitude; the block turns the magnitude into a log height,
// moves that band's bar and peak marker when update is set, and returns one
// result with the whole-pixel bar and peak heights. Throughput is one item per
// clock unless a same-band wait or result stall holds it. Height math sits in
// f1 to f3, the queue, then state update in s1 to s3 and the output register.
// Per-band state sits in a 256-entry memory with one write port; when an
// updating item of a band is followed within three issued items by the same
// band, the later one waits for that write. Distinct bands stream at full rate.
// Configuration writes are taken every cycle and must only happen while idle.
module spectrum_bar_peak_ballistics_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                item_valid,
    output logic                                     item_stall,
    input  wire sbpb_pkg::item_t                     item,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output sbpb_pkg::result_t                        result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sbpb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sbpb_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sbpb_pkg::*;

    cfg_t cfg_reg;
    logic q_full, push, pop, head_valid;
    job_t push_job, head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.log_scale    <= 16'd24545;
            cfg_reg.height_limit <= 12'd255;
            cfg_reg.bar_decay    <= 14'd1271;
            cfg_reg.peak_accel   <= 11'd1103;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LOG_SCALE:    cfg_reg.log_scale    <= cfg_data;
                REG_HEIGHT_LIMIT: cfg_reg.height_limit <= cfg_data[11:0];
                REG_BAR_DECAY:    cfg_reg.bar_decay    <= cfg_data[13:0];
                REG_PEAK_ACCEL:   cfg_reg.peak_accel   <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    sbpb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .push       (push),
        .job        (push_job)
    );

    sbpb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    sbpb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire

// ----- sim/tb_spectrum_bar_peak_ballistics_top.sv -----
`timescale 1ns / 100ps

module tb_spectrum_bar_peak_ballistics_top;

    import sbpb_pkg::*;

    localparam logic [23:0] FALL_SPEED_INIT = 24'd655;
    localparam int          WATCHDOG_LIMIT  = 5000;
    localparam int          LONG_HOLD       = 300;
    localparam int          PHASE_ITEMS     = 190;
    localparam int          RANDOM_PHASES   = 8;

    // log_scale, height_limit, bar_decay, peak_accel
    localparam cfg_t PRESETS [6] = '{
        '{16'd65535, 12'd4095, 14'd10000, 11'd2000},
        '{16'd0,     12'd0,    14'd0,     11'd1000},
        '{16'd24545, 12'd255,  14'd0,     11'd2000},  // bar holds, fall speed saturates
        '{16'd40000, 12'd1000, 14'd500,   11'd900},   // speed shrinks toward zero
        '{16'd24545, 12'd255,  14'd1271,  11'd1103},
        '{16'd12000, 12'd4095, 14'd3,     11'd1500}
    };

    localparam item_t OPENING_ITEMS [19] = '{
        '{8'd0,   24'hFFFFFF, 1'b1},
        '{8'd0,   24'h123456, 1'b0},
        '{8'd0,   24'h000000, 1'b1},
        '{8'd0,   24'h000000, 1'b1},
        '{8'd0,   24'h000000, 1'b1},
        '{8'd255, 24'h000100, 1'b1},  // exactly 1.0 gives zero height
        '{8'd255, 24'h0001FF, 1'b1},
        '{8'd1,   24'h000001, 1'b1},  // leading one below mantissa width
        '{8'd2,   24'h000020, 1'b1},
        '{8'd3,   24'h000040, 1'b1},
        '{8'd254, 24'h800000, 1'b1},
        '{8'd4,   24'hFFFFFF, 1'b1},
        '{8'd4,   24'h010000, 1'b1},
        '{8'd4,   24'h010000, 1'b1},
        '{8'd4,   24'h010000, 1'b1},
        '{8'd5,   24'hABCDEF, 1'b0},  // never touched band
        '{8'd170, 24'h555555, 1'b1},
        '{8'd85,  24'hAAAAAA, 1'b1},
        '{8'd4,   24'hFFFFFF, 1'b0}
    };

    class meter_scoreboard;
        bit [15:0] mant_frac [64];
        bit [19:0] bar_height [BANDS];
        bit [19:0] peak_height [BANDS];
        bit [23:0] fall_rate [BANDS];
        bit [15:0] scale_q8;
        bit [11:0] height_cap;
        bit [13:0] decay_milli;
        bit [10:0] accel_milli;
        result_t   pending_heights [$];
        int        errors;
        int        items_seen;
        int        results_checked;

        function new();
            bit [63:0] y;
            bit [15:0] r;
            for (int m = 0; m < 64; m++)
            begin
                y = 64'(64 + m) << 24;
                r = '0;
                for (int b = 15; b >= 0; b--)
                begin
                    y = (y * y) >> 30;
                    if (y >= (64'd2 << 30))
                    begin
                        r[b] = 1'b1;
                        y    = y >> 1;
                    end
                end
                mant_frac[m] = r;
            end
            for (int i = 0; i < BANDS; i++)
            begin
                bar_height[i]  = '0;
                peak_height[i] = '0;
                fall_rate[i]   = FALL_SPEED_INIT;
            end
            scale_q8        = 16'd24545;
            height_cap      = 12'd255;
            decay_milli     = 14'd1271;
            accel_milli     = 11'd1103;
            errors          = 0;
            items_seen      = 0;
            results_checked = 0;
        endfunction

        function void set_reg(reg_index_t idx, bit [15:0] val);
            case (idx)
                REG_LOG_SCALE:    scale_q8    = val;
                REG_HEIGHT_LIMIT: height_cap  = val[11:0];
                REG_BAR_DECAY:    decay_milli = val[13:0];
                REG_PEAK_ACCEL:   accel_milli = val[10:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return pending_heights.size();
        endfunction

        // Q12.8 height from the log of a Q16.8 magnitude
        function bit [19:0] log_height(bit [23:0] lvl);
            int        p;
            int        m;
            longint    lq;
            bit [63:0] d;
            bit [63:0] h;
            bit [63:0] lim;
            p = -1;
            for (int k = 23; k >= 0; k--)
                if (lvl[k] && p < 0)
                    p = k;
            if (p < 0)
                return '0;
            if (p >= 6)
                m = int'(lvl >> (p - 6)) & 63;
            else
                m = (int'(lvl) << (6 - p)) & 63;
            lq = longint'(p - 8) * 65536 + longint'(mant_frac[m]);
            if (lq <= 0)
                return '0;
            d   = ($unsigned(lq) * 64'd19728) >> 16;
            h   = (d * 64'(scale_q8)) >> 16;
            lim = 64'(height_cap) << 8;
            if (h > lim)
                h = lim;
            return h[19:0];
        endfunction

        function void note_band_item(item_t it);
            bit [63:0] h;
            bit [63:0] bar;
            bit [63:0] pk;
            bit [63:0] spd;
            bit [63:0] dec;
            bit [63:0] drop;
            bit        falling;
            result_t   want;
            items_seen++;
            if (it.update)
            begin
                h       = 64'(log_height(it.level));
                bar     = 64'(bar_height[it.band]);
                pk      = 64'(peak_height[it.band]);
                spd     = 64'(fall_rate[it.band]);
                falling = 1'b1;
                if (h > bar)
                begin
                    bar = h;
                    if (h > pk)
                    begin
                        pk      = h;
                        spd     = 64'(FALL_SPEED_INIT);
                        falling = 1'b0;
                    end
                end
                else if (bar > 0)
                begin
                    dec = (64'(decay_milli) * 256 + 500) / 1000;
                    bar = (bar > dec) ? bar - dec : 64'd0;
                end
                if (falling && pk > 0)
                begin
                    drop = (spd + 128) >> 8;
                    pk   = (pk > drop) ? pk - drop : 64'd0;
                    spd  = (spd * 64'(accel_milli) + 500) / 1000;
                    if (spd > 64'hFFFFFF)
                        spd = 64'hFFFFFF;
                    if (pk < bar)
                        pk = bar;
                end
                bar_height[it.band]  = bar[19:0];
                peak_height[it.band] = pk[19:0];
                fall_rate[it.band]   = spd[23:0];
            end
            want.band_out    = it.band;
            want.bar_pixels  = bar_height[it.band][19:8];
            want.peak_pixels = peak_height[it.band][19:8];
            pending_heights.push_back(want);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_heights(result_t got);
            result_t want;
            results_checked++;
            if (pending_heights.size() == 0)
            begin
                report($sformatf("unexpected beat band %0d bar %0d peak %0d",
                                 got.band_out, got.bar_pixels, got.peak_pixels));
                return;
            end
            want = pending_heights.pop_front();
            if (got.band_out != want.band_out)
                report($sformatf("band_out got %0d want %0d", got.band_out, want.band_out));
            if (got.bar_pixels != want.bar_pixels)
                report($sformatf("band %0d bar_pixels got %0d want %0d",
                                 want.band_out, got.bar_pixels, want.bar_pixels));
            if (got.peak_pixels != want.peak_pixels)
                report($sformatf("band %0d peak_pixels got %0d want %0d",
                                 want.band_out, got.peak_pixels, want.peak_pixels));
        endtask
    endclass

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    item_t                 item         = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    meter_scoreboard sb = new();
    idle_mode_e      idle_mode    = IDLE_NONE;
    int              rx_hold_left = 0;
    int              quiet_cycles = 0;
    logic [7:0]      prev_band    = '0;

    spectrum_bar_peak_ballistics_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // input beat is noted before the output check of the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                sb.note_band_item(item);
            if (result_valid && !result_stall)
                sb.check_heights(result);
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles, %0d results still due",
                         quiet_cycles, sb.outstanding());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            result_stall <= 1'b1;
            rx_hold_left <= rx_hold_left - 1;
        end
        else
            result_stall <= ($urandom_range(0, 99) <
                ((idle_mode == IDLE_RECV) ? 52 : (idle_mode == IDLE_BOTH) ? 6 : 0));
    end

    function automatic int send_idle_pct();
        return (idle_mode == IDLE_SEND) ? 52 : (idle_mode == IDLE_BOTH) ? 6 : 0;
    endfunction

    // entered and left at a falling edge; valid stays high into the next call
    task automatic send_item(item_t it);
        logic [63:0] noise;
        while ($urandom_range(0, 99) < send_idle_pct())
        begin
            noise      = {$urandom(), $urandom()};
            item_valid <= 1'b0;
            item       <= noise[$bits(item_t)-1:0];
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        @(negedge clk);
        while (sb.outstanding() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
    endtask

    // mostly a small window of bands so ballistics and same-band hazards build up
    function automatic item_t random_item(int span, logic [7:0] base);
        item_t it;
        if ($urandom_range(0, 99) < 15)
            it.band = 8'($urandom_range(0, 255));
        else if ($urandom_range(0, 9) == 0)
            it.band = prev_band;
        else
            it.band = base + 8'($urandom_range(0, span - 1));
        case ($urandom_range(0, 9))
            0:       it.level = '0;
            1:       it.level = 24'($urandom_range(0, 255));
            2:       it.level = 24'hFFFFFF;
            3, 4, 5: it.level = 24'($urandom());
            default: it.level = 24'($urandom() >> $urandom_range(8, 31));
        endcase
        it.update = ($urandom_range(0, 99) < 85);
        prev_band = it.band;
        return it;
    endfunction

    task automatic run_phase(int count, int span);
        logic [7:0] base;
        base = 8'($urandom_range(0, 255));
        for (int n = 0; n < count; n++)
            send_item(random_item(span, base));
    endtask

    initial
    begin
        cfg_t setting;
        int   span;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // opening items run at the reset register values
        foreach (OPENING_ITEMS[i])
            send_item(OPENING_ITEMS[i]);
        drain_results();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph < 6)
                setting = PRESETS[ph];
            else
            begin
                setting.log_scale    = 16'($urandom_range(0, 65535));
                setting.height_limit = 12'($urandom_range(0, 4095));
                setting.bar_decay    = 14'($urandom_range(0, 10000));
                setting.peak_accel   = 11'($urandom_range(1000, 2000));
            end
            write_reg(REG_LOG_SCALE, setting.log_scale);
            write_reg(REG_HEIGHT_LIMIT, 16'(setting.height_limit));
            write_reg(REG_BAR_DECAY, 16'(setting.bar_decay));
            write_reg(REG_PEAK_ACCEL, 16'(setting.peak_accel));
            cfg_valid <= 1'b0;
            idle_mode = idle_mode_e'(ph % 4);
            span = (ph == 2) ? 4 : (ph == 0) ? 16 : 8;
            if (ph == 2)
            begin
                // receiver holds off while the sender keeps offering beats
                @(posedge clk);
                rx_hold_left = LONG_HOLD;
                @(negedge clk);
            end
            if (ph == 4)
            begin
                run_phase(PHASE_ITEMS / 2, span);
                drain_results();
                run_phase(PHASE_ITEMS / 2, span);
            end
            else
                run_phase(PHASE_ITEMS, span);
            drain_results();
        end

        repeat (20) @(negedge clk);
        $display("covered %0d band items over reset values and %0d register settings",
                 sb.items_seen, RANDOM_PHASES);
        $display("checked %0d result beats, %0d mismatches", sb.results_checked, sb.errors);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
